// ===== src/glht_pkg.sv =====
// shared types, constants and divider step for the grid layout hit test unit
package glht_pkg;

	localparam int MARGIN_DEF          = 8;
	localparam int MIN_CELL_WIDTH_DEF  = 100;
	localparam int MIN_CELL_HEIGHT_DEF = 120;
	localparam int LABEL_HEIGHT_DEF    = 20;

	localparam int COORD_W     = 12;
	localparam int COUNT_W     = 16;
	localparam int PITCH_W     = 13;
	localparam int DIV_STEPS   = COORD_W;
	localparam int STAGE_STEPS = DIV_STEPS / 3;
	localparam int LABEL_TRIM  = 4;

	typedef enum logic [2:0] {
		REG_CONTENT_WIDTH   = 3'd0,
		REG_CONTENT_HEIGHT  = 3'd1,
		REG_BOTTOM_RESERVE  = 3'd2,
		REG_MAX_CELL_HEIGHT = 3'd3,
		REG_ORIGIN_X        = 3'd4,
		REG_ORIGIN_Y        = 3'd5,
		REG_PAGE_FIRST_ROW  = 3'd6,
		REG_ITEM_TOTAL      = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
	} point_t;

	typedef struct packed {
		logic               hit;
		logic [COUNT_W-1:0] item_index;
		logic [COORD_W-1:0] column_count;
		logic [COORD_W-1:0] row_count;
		logic [COORD_W-1:0] cell_w;
		logic [COORD_W-1:0] cell_h;
		logic [COORD_W-1:0] label_w;
		logic [PITCH_W-1:0] row_pitch;
	} result_t;

	typedef struct packed {
		logic [COORD_W-1:0] cols;
		logic [COORD_W-1:0] rows;
		logic [COORD_W-1:0] cw;
		logic [COORD_W-1:0] ch;
		logic [COORD_W-1:0] lw;
		logic [PITCH_W-1:0] pitch;
	} layout_t;

	// restoring divider state: partial remainder, dividend bits left, quotient so far
	typedef struct packed {
		logic [COORD_W-1:0] rem;
		logic [COORD_W-1:0] num;
		logic [COORD_W-1:0] quo;
	} div_t;

	function automatic div_t div_init(logic [COORD_W-1:0] n);
		div_t o;
		o.rem = '0;
		o.num = n;
		o.quo = '0;
		return o;
	endfunction

	// one quotient bit; partial remainder never exceeds the 12-bit dividend
	function automatic div_t div_step(div_t d, logic [PITCH_W-1:0] dvs);
		div_t o;
		logic [COORD_W-1:0] r;
		logic ge;
		r = {d.rem[COORD_W-2:0], d.num[COORD_W-1]};
		ge = {1'b0, r} >= dvs;
		o.rem = ge ? COORD_W'({1'b0, r} - dvs) : r;
		o.num = {d.num[COORD_W-2:0], 1'b0};
		o.quo = {d.quo[COORD_W-2:0], ge};
		return o;
	endfunction

endpackage

// ===== src/glht_layout.sv =====
// layout solver: column count by reciprocal multiply, cell sizes through one serial divider
module glht_layout import glht_pkg::*; #(
	parameter int MARGIN          = MARGIN_DEF,
	parameter int MIN_CELL_WIDTH  = MIN_CELL_WIDTH_DEF,
	parameter int MIN_CELL_HEIGHT = MIN_CELL_HEIGHT_DEF,
	parameter int LABEL_HEIGHT    = LABEL_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               recalc,
	input  logic [COORD_W-1:0] content_width,
	input  logic [COORD_W-1:0] content_height,
	input  logic [COORD_W-1:0] bottom_reserve,
	input  logic [COORD_W-1:0] max_cell_height,
	output logic               busy,
	output layout_t            lay
);

	localparam int ROW_EXTRA = LABEL_HEIGHT + MARGIN;
	// column pitch divide done as multiply by a rounded-up reciprocal, exact for 12-bit widths
	localparam int     COL_DIV  = MIN_CELL_WIDTH + MARGIN;
	localparam int     RECIP_SH = 24;
	localparam longint RECIP_M  =
		((longint'(1) <<< RECIP_SH) + longint'(COL_DIV) - 1) / longint'(COL_DIV);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_COLS = 5'b00010,
		ST_CW   = 5'b00100,
		ST_ROWS = 5'b01000,
		ST_FIT  = 5'b10000
	} lay_state_t;

	lay_state_t         state_q, state_d;
	logic [3:0]         cnt_q, cnt_d;
	logic               dirty_q, dirty_d;
	div_t               dv_q, dv_d, dv_nxt;
	logic [PITCH_W-1:0] dvs_q, dvs_d;
	layout_t            lay_q, lay_d;

	logic               last;
	logic [COORD_W-1:0] qnz, hmax, usable, tnum, fitted, chv;
	logic [19:0]        gutter_sum, tw;
	logic [COORD_W-1:0] cols_num, cols_raw, cols_c;
	logic [39:0]        cols_prod;

	assign dv_nxt = div_step(dv_q, dvs_q);
	assign last   = cnt_q == 4'(DIV_STEPS - 1);
	assign qnz    = (dv_nxt.quo == '0) ? COORD_W'(1) : dv_nxt.quo;
	assign hmax   = (max_cell_height < COORD_W'(MIN_CELL_HEIGHT)) ?
		COORD_W'(MIN_CELL_HEIGHT) : max_cell_height;
	assign usable = (content_height > bottom_reserve) ? content_height - bottom_reserve : '0;

	// columns: (width - margin) / column pitch, at least one
	assign cols_num  = (PITCH_W'(content_width) > PITCH_W'(MARGIN)) ?
		content_width - COORD_W'(MARGIN) : '0;
	assign cols_prod = 40'(cols_num) * 40'(RECIP_M);
	assign cols_raw  = cols_prod[RECIP_SH +: COORD_W];
	assign cols_c    = (cols_raw == '0) ? COORD_W'(1) : cols_raw;

	// space left for cells once cols + 1 gutters are taken out
	assign gutter_sum = (20'(lay_q.cols) + 20'd1) * 20'(MARGIN);
	assign tw         = 20'(content_width) - gutter_sum;
	assign tnum       = (!tw[19] && tw != '0) ? tw[COORD_W-1:0] : '0;

	assign fitted = dv_nxt.quo - COORD_W'(ROW_EXTRA);
	assign chv = ({1'b0, dv_nxt.quo} < PITCH_W'(ROW_EXTRA + MIN_CELL_HEIGHT)) ?
		COORD_W'(MIN_CELL_HEIGHT) : ((fitted < hmax) ? fitted : hmax);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q + 4'd1;
		dirty_d = dirty_q | recalc;
		dv_d    = dv_nxt;
		dvs_d   = dvs_q;
		lay_d   = lay_q;
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				dv_d  = dv_q;
				if (dirty_q) begin
					dirty_d    = recalc;
					state_d    = ST_COLS;
					lay_d.cols = cols_c;
				end
			end
			ST_COLS: begin
				cnt_d   = '0;
				dv_d    = div_init(tnum);
				dvs_d   = {1'b0, lay_q.cols};
				state_d = ST_CW;
			end
			ST_CW: begin
				if (last) begin
					lay_d.cw = qnz;
					lay_d.lw = (qnz > COORD_W'(LABEL_TRIM)) ? qnz - COORD_W'(LABEL_TRIM) : '0;
					cnt_d    = '0;
					dv_d     = div_init(usable);
					dvs_d    = PITCH_W'(hmax) + PITCH_W'(ROW_EXTRA);
					state_d  = ST_ROWS;
				end
			end
			ST_ROWS: begin
				if (last) begin
					lay_d.rows = qnz;
					cnt_d      = '0;
					dv_d       = div_init(usable);
					dvs_d      = {1'b0, qnz};
					state_d    = ST_FIT;
				end
			end
			ST_FIT: begin
				if (last) begin
					lay_d.ch    = chv;
					lay_d.pitch = PITCH_W'(chv) + PITCH_W'(ROW_EXTRA);
					cnt_d       = '0;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			dirty_q <= 1'b1;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			dirty_q <= dirty_d;
		end
	end

	always_ff @(posedge clk) begin
		dv_q  <= dv_d;
		dvs_q <= dvs_d;
		lay_q <= lay_d;
	end

	assign busy = dirty_q || (state_q != ST_IDLE);
	assign lay  = lay_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < 4'(DIV_STEPS))
		else $error("layout divider ran past its step count");

endmodule

// ===== src/glht_hit.sv =====
// six-stage hit test pipeline: offsets, pipelined row and column division, index
module glht_hit import glht_pkg::*; #(
	parameter int MARGIN       = MARGIN_DEF,
	parameter int LABEL_HEIGHT = LABEL_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               take,
	input  point_t             pt,
	input  layout_t            lay,
	input  logic [COORD_W-1:0] origin_x,
	input  logic [COORD_W-1:0] origin_y,
	input  logic [COUNT_W-1:0] page_first_row,
	input  logic [COUNT_W-1:0] item_total,
	output logic               valid,
	output logic               hit,
	output logic [COUNT_W-1:0] item_index
);

	localparam int PROD_W = COUNT_W + 1 + COORD_W;

	logic [13:0]        dyw, dxw;
	logic [PITCH_W-1:0] cstride;
	div_t               x2_d, y2_d, x3_d, y3_d, x4_d, y4_d;
	logic               inr;
	logic [PROD_W:0]    idx;
	logic               hit_d;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic               ok_s1, ok_s2, ok_s3, ok_s4, inr_s5;
	div_t               x_s1, y_s1, x_s2, y_s2, x_s3, y_s3, x_s4, y_s4;
	logic [PROD_W-1:0]  prod_s5;
	logic [COORD_W-1:0] col_s5;
	logic               hit_s6;
	logic [COUNT_W-1:0] idx_s6;

	assign dyw     = 14'(pt.point_y) - 14'(origin_y);
	assign dxw     = 14'(pt.point_x) - 14'(origin_x) - 14'(MARGIN);
	assign cstride = PITCH_W'(lay.cw) + PITCH_W'(MARGIN);

	always_comb begin
		x2_d = x_s1;
		y2_d = y_s1;
		x3_d = x_s2;
		y3_d = y_s2;
		x4_d = x_s3;
		y4_d = y_s3;
		for (int i = 0; i < STAGE_STEPS; i++) begin
			x2_d = div_step(x2_d, cstride);
			y2_d = div_step(y2_d, lay.pitch);
			x3_d = div_step(x3_d, cstride);
			y3_d = div_step(y3_d, lay.pitch);
			x4_d = div_step(x4_d, cstride);
			y4_d = div_step(y4_d, lay.pitch);
		end
	end

	// the remainders are the offsets inside the row pitch and column stride
	assign inr = ok_s4 && (y_s4.quo < lay.rows) &&
		(PITCH_W'(y_s4.rem) < PITCH_W'(lay.ch) + PITCH_W'(LABEL_HEIGHT)) &&
		(x_s4.quo < lay.cols) && (x_s4.rem < lay.cw);

	assign idx   = (PROD_W + 1)'(prod_s5) + (PROD_W + 1)'(col_s5);
	assign hit_d = inr_s5 && (idx < (PROD_W + 1)'(item_total));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1   <= !dyw[13] && !dxw[13];
			x_s1    <= div_init(dxw[COORD_W-1:0]);
			y_s1    <= div_init(dyw[COORD_W-1:0]);
			ok_s2   <= ok_s1;
			x_s2    <= x2_d;
			y_s2    <= y2_d;
			ok_s3   <= ok_s2;
			x_s3    <= x3_d;
			y_s3    <= y3_d;
			ok_s4   <= ok_s3;
			x_s4    <= x4_d;
			y_s4    <= y4_d;
			inr_s5  <= inr;
			prod_s5 <= PROD_W'((17'(page_first_row) + 17'(y_s4.quo)) * 29'(lay.cols));
			col_s5  <= x_s4.quo;
			hit_s6  <= hit_d;
			idx_s6  <= hit_d ? idx[COUNT_W-1:0] : '0;
		end
	end

	assign valid      = v_s6;
	assign hit        = hit_s6;
	assign item_index = idx_s6;

endmodule

// ===== src/grid_layout_hit_test_unit.sv =====
// top level of the grid layout hit test unit: registers, layout solver, hit pipeline
//
// lays out a grid of item cells from the panel registers and, for each pointer beat,
// reports the item cell under the pointer along with the layout values. once the layout
// is settled, one pointer beat is taken every cycle unless the result side stalls, and
// its result passes through the offset stage, three division stages taking four
// quotient bits each for row and column, the index multiply and the index compare.
// after reset and after every configuration write the layout is rebuilt: a reciprocal
// multiply gives the column count, then one shared serial divider does three 12-step
// divisions; point_stall is high throughout, and configuration writes are always taken.
// a stall on the result side holds the whole pipeline in place.
module grid_layout_hit_test_unit import glht_pkg::*; #(
	parameter int MARGIN          = MARGIN_DEF,
	parameter int MIN_CELL_WIDTH  = MIN_CELL_WIDTH_DEF,
	parameter int MIN_CELL_HEIGHT = MIN_CELL_HEIGHT_DEF,
	parameter int LABEL_HEIGHT    = LABEL_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// pointer beats
	input  logic               point_valid,
	output logic               point_stall,
	input  point_t             point,
	// result beats
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	// register writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [COUNT_W-1:0] cfg_data
);

	logic [COORD_W-1:0] content_width_q, content_height_q, bottom_reserve_q;
	logic [COORD_W-1:0] max_cell_height_q, origin_x_q, origin_y_q;
	logic [COUNT_W-1:0] page_first_row_q, item_total_q;

	logic    cfg_wr;
	logic    busy;
	logic    adv;
	logic    take;
	logic    hit;
	logic [COUNT_W-1:0] item_index;
	layout_t lay;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			content_width_q   <= '0;
			content_height_q  <= '0;
			bottom_reserve_q  <= '0;
			max_cell_height_q <= '0;
			origin_x_q        <= '0;
			origin_y_q        <= '0;
			page_first_row_q  <= '0;
			item_total_q      <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_CONTENT_WIDTH:   content_width_q   <= cfg_data[COORD_W-1:0];
				REG_CONTENT_HEIGHT:  content_height_q  <= cfg_data[COORD_W-1:0];
				REG_BOTTOM_RESERVE:  bottom_reserve_q  <= cfg_data[COORD_W-1:0];
				REG_MAX_CELL_HEIGHT: max_cell_height_q <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_X:        origin_x_q        <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Y:        origin_y_q        <= cfg_data[COORD_W-1:0];
				REG_PAGE_FIRST_ROW:  page_first_row_q  <= cfg_data;
				REG_ITEM_TOTAL:      item_total_q      <= cfg_data;
			endcase
		end
	end

	// layout rebuild after reset and after any register write
	glht_layout #(
		.MARGIN          (MARGIN),
		.MIN_CELL_WIDTH  (MIN_CELL_WIDTH),
		.MIN_CELL_HEIGHT (MIN_CELL_HEIGHT),
		.LABEL_HEIGHT    (LABEL_HEIGHT)
	) u_layout (
		.clk             (clk),
		.arst_n          (arst_n),
		.recalc          (cfg_wr),
		.content_width   (content_width_q),
		.content_height  (content_height_q),
		.bottom_reserve  (bottom_reserve_q),
		.max_cell_height (max_cell_height_q),
		.busy            (busy),
		.lay             (lay)
	);

	// the pipeline moves unless a finished result sits stalled at the output
	assign adv         = !(result_valid && result_stall);
	assign point_stall = busy || !adv;
	assign take        = point_valid && !point_stall;

	glht_hit #(
		.MARGIN       (MARGIN),
		.LABEL_HEIGHT (LABEL_HEIGHT)
	) u_hit (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.take           (take),
		.pt             (point),
		.lay            (lay),
		.origin_x       (origin_x_q),
		.origin_y       (origin_y_q),
		.page_first_row (page_first_row_q),
		.item_total     (item_total_q),
		.valid          (result_valid),
		.hit            (hit),
		.item_index     (item_index)
	);

	// layout fields hold steady between register writes, so they ride along directly
	always_comb begin
		result.hit          = hit;
		result.item_index   = item_index;
		result.column_count = lay.cols;
		result.row_count    = lay.rows;
		result.cell_w       = lay.cw;
		result.cell_h       = lay.ch;
		result.label_w      = lay.lw;
		result.row_pitch    = lay.pitch;
	end

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.hit |-> result.item_index < item_total_q)
		else $error("hit reported on an index past the item count");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hit |-> result.item_index == '0)
		else $error("miss carries a nonzero index");

	a_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> lay.pitch == PITCH_W'(lay.ch) + PITCH_W'(LABEL_HEIGHT + MARGIN))
		else $error("row pitch out of step with cell height");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !take)
		else $error("pointer beat taken during layout rebuild");

endmodule
